// File: sv/szs_pkg.sv
package szs_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 24;

  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int WLEN_W     = 7;
  localparam int THR_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int KW         = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(1);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(768);

  // datapath widths
  localparam int SUM_W = SAMPLE_BITS + IDX_W;            // signed window sum
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + IDX_W;    // sum of squares
  localparam int WQ_W  = SQ_W + WLEN_W;                  // w*Q and spread
  localparam int DEV_W = SAMPLE_BITS + WLEN_W;           // |w*x - S|
  localparam int D_W   = SAMPLE_BITS + WLEN_W + IDX_W + 1;
  localparam int LHS_W = 2 * DEV_W + 16;

  // multiplier digits
  localparam int DIG_W = 32;
  localparam int ND    = (WQ_W + DIG_W - 1) / DIG_W;
  localparam int OP_W  = ND * DIG_W;
  localparam int ACC_W = 2 * OP_W;
  localparam int ND_W  = (ND > 1) ? $clog2(ND) : 1;
  localparam int SH_W  = $clog2(2 * ND);

  localparam int ND_Q  = (SQ_W + DIG_W - 1) / DIG_W;
  localparam int ND_S  = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int ND_D  = (DEV_W + DIG_W - 1) / DIG_W;
  localparam int ND_WQ = (WQ_W + DIG_W - 1) / DIG_W;

  typedef logic [SAMPLE_BITS-1:0]      sample_t;
  typedef logic [WLEN_W-1:0]           wlen_t;
  typedef logic [THR_W-1:0]            thr_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [COUNT_W-1:0]          count_t;
  typedef logic [ND-1:0][DIG_W-1:0]    digits_t;
  typedef logic [ACC_W-1:0]            acc_t;
  typedef logic [ND_W-1:0]             dig_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_MUL,
    ST_DRAIN,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    J_SWEEP,   // ring sweep: S and Q
    J_WQ,      // w*Q
    J_SS,      // S^2
    J_WX,      // w*|x|
    J_DD,      // dev^2
    J_TT,      // T^2
    J_RHS      // spread*T^2
  } job_t;

  typedef struct packed {
    sample_t x;
    wlen_t   w;
    cnt_t    n;
    logic    full;
    thr_t    thr;
    idx_t    top_addr;
  } start_t;

  typedef struct packed {
    logic anomaly;
    logic window_full;
  } result_t;

  function automatic wlen_t clamp_wlen(input wlen_t wl);
    wlen_t r;
    if (wl == '0) begin
      r = WLEN_W'(1);
    end else if (KW'(wl) > KW'(MAX_WINDOW)) begin
      r = WLEN_W'(MAX_WINDOW);
    end else begin
      r = wl;
    end
    return r;
  endfunction

  function automatic dig_idx_t job_last_a(input job_t j);
    dig_idx_t r;
    unique case (j)
      J_WQ:    r = ND_W'(ND_Q - 1);
      J_SS:    r = ND_W'(ND_S - 1);
      J_DD:    r = ND_W'(ND_D - 1);
      J_RHS:   r = ND_W'(ND_WQ - 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic dig_idx_t job_last_b(input job_t j);
    dig_idx_t r;
    unique case (j)
      J_SS:    r = ND_W'(ND_S - 1);
      J_DD:    r = ND_W'(ND_D - 1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/szs_in_if.sv
interface szs_in_if;
  import szs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

// File: sv/szs_out_if.sv
interface szs_out_if;
  import szs_pkg::*;

  logic               valid;
  logic               ready;
  logic               anomaly;
  logic               window_full;
  logic [COUNT_W-1:0] anomaly_count;

  modport source (output valid, output anomaly, output window_full, output anomaly_count,
                  input ready);
  modport sink   (input valid, input anomaly, input window_full, input anomaly_count,
                  output ready);
endinterface

// File: sv/szs_ram.sv
module szs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/szs_mul.sv
module szs_mul (
  input  logic                           clk,
  input  logic [szs_pkg::DIG_W-1:0]      a,
  input  logic [szs_pkg::DIG_W-1:0]      b,
  output logic [2*szs_pkg::DIG_W-1:0]    p
);
  import szs_pkg::*;

  logic [2*DIG_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// File: sv/szs_core.sv
module szs_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start_valid,
  output logic                            start_ready,
  input  szs_pkg::start_t                 start,
  output logic                            done_valid,
  input  logic                            done_ready,
  output szs_pkg::result_t                result,
  output logic [szs_pkg::IDX_W-1:0]       rd_addr,
  input  logic [szs_pkg::SAMPLE_BITS-1:0] rd_data
);
  import szs_pkg::*;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  wlen_t    w_r, w_nxt;
  cnt_t     n_r, n_nxt;
  logic     full_r, full_nxt;
  thr_t     thr_r, thr_nxt;
  idx_t     addr_r, addr_nxt;
  cnt_t     k_r, k_nxt;
  dig_idx_t i_r, i_nxt, j_r, j_nxt;
  logic     rdv_r, rdv_nxt;
  logic     pv_r, pv_nxt;
  logic [SH_W-1:0] sh_r, sh_nxt;
  acc_t     acc_r, acc_nxt;

  logic signed [SUM_W-1:0] s_r, s_nxt;
  logic [SQ_W-1:0]         q_r, q_nxt;
  logic [WQ_W-1:0]         spread_r, spread_nxt;
  logic [DEV_W-1:0]        dev_r, dev_nxt;
  logic [LHS_W-1:0]        lhs_r, lhs_nxt;
  logic [2*THR_W-1:0]      tsq_r, tsq_nxt;
  logic                    anom_r, anom_nxt;

  logic [SAMPLE_BITS-1:0]  rd_mag;
  logic [SAMPLE_BITS-1:0]  x_mag;
  logic [SUM_W-1:0]        s_mag;
  digits_t                 opa, opb;
  logic [DIG_W-1:0]        a_dig, b_dig, mul_a, mul_b;
  logic [2*DIG_W-1:0]      mul_p;
  logic signed [D_W-1:0]   wx_s, diff_s, dev_abs;
  dig_idx_t                last_a, last_b;
  logic                    last_pair;

  szs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign start_ready        = (state_r == ST_IDLE);
  assign done_valid         = (state_r == ST_DONE);
  assign result.anomaly     = anom_r;
  assign result.window_full = full_r;
  assign rd_addr            = addr_r;

  assign rd_mag = rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data;
  assign x_mag  = x_r[SAMPLE_BITS-1] ? (~x_r + 1'b1) : x_r;
  assign s_mag  = s_r[SUM_W-1] ? (~s_r + 1'b1) : s_r;

  assign last_a    = job_last_a(job_r);
  assign last_b    = job_last_b(job_r);
  assign last_pair = (i_r == last_a) && (j_r == last_b);

  // operand select for the current product
  always_comb begin
    unique case (job_r)
      J_WQ: begin
        opa = OP_W'(q_r);
        opb = OP_W'(w_r);
      end
      J_SS: begin
        opa = OP_W'(s_mag);
        opb = OP_W'(s_mag);
      end
      J_WX: begin
        opa = OP_W'(x_mag);
        opb = OP_W'(w_r);
      end
      J_DD: begin
        opa = OP_W'(dev_r);
        opb = OP_W'(dev_r);
      end
      J_TT: begin
        opa = OP_W'(thr_r);
        opb = OP_W'(thr_r);
      end
      J_RHS: begin
        opa = OP_W'(spread_r);
        opb = OP_W'(tsq_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign a_dig = opa[i_r];
  assign b_dig = opb[j_r];
  assign mul_a = rdv_r ? DIG_W'(rd_mag) : a_dig;
  assign mul_b = rdv_r ? DIG_W'(rd_mag) : b_dig;

  // signed w*x from the unsigned product, then the deviation
  assign wx_s    = x_r[SAMPLE_BITS-1] ? -$signed(acc_r[D_W-1:0]) : $signed(acc_r[D_W-1:0]);
  assign diff_s  = wx_s - D_W'(s_r);
  assign dev_abs = diff_s[D_W-1] ? -diff_s : diff_s;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_valid) state_nxt = ST_SWEEP;
      ST_SWEEP: if (k_r == n_r - 1'b1) state_nxt = ST_DRAIN;
      ST_MUL:   if (last_pair) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rdv_r) state_nxt = ST_STORE;
      ST_STORE: begin
        if ((job_r == J_SWEEP && !full_r) || job_r == J_RHS) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE:  if (done_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_nxt    = job_r;
    x_nxt      = x_r;
    w_nxt      = w_r;
    n_nxt      = n_r;
    full_nxt   = full_r;
    thr_nxt    = thr_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    spread_nxt = spread_r;
    dev_nxt    = dev_r;
    lhs_nxt    = lhs_r;
    tsq_nxt    = tsq_r;
    anom_nxt   = anom_r;
    acc_nxt    = acc_r;

    rdv_nxt = (state_r == ST_SWEEP);
    pv_nxt  = rdv_r || (state_r == ST_MUL);
    sh_nxt  = rdv_r ? '0 : (SH_W'(i_r) + SH_W'(j_r));

    if (pv_r) begin
      acc_nxt = acc_r + (ACC_W'(mul_p) << (DIG_W * sh_r));
    end
    if (rdv_r) begin
      s_nxt = s_r + SUM_W'($signed(rd_data));
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start_valid) begin
          x_nxt    = start.x;
          w_nxt    = start.w;
          n_nxt    = start.n;
          full_nxt = start.full;
          thr_nxt  = start.thr;
          addr_nxt = start.top_addr;
          k_nxt    = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          acc_nxt  = '0;
          s_nxt    = '0;
          job_nxt  = J_SWEEP;
        end
      end
      ST_SWEEP: begin
        // walk from the newest entry backward
        k_nxt    = k_r + 1'b1;
        addr_nxt = (addr_r == '0) ? IDX_W'(MAX_WINDOW - 1) : addr_r - 1'b1;
      end
      ST_MUL: begin
        if (j_r == last_b) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_STORE: begin
        acc_nxt = '0;
        i_nxt   = '0;
        j_nxt   = '0;
        unique case (job_r)
          J_SWEEP: begin
            q_nxt    = acc_r[SQ_W-1:0];
            anom_nxt = 1'b0;
            job_nxt  = J_WQ;
          end
          J_WQ: begin
            spread_nxt = acc_r[WQ_W-1:0];
            job_nxt    = J_SS;
          end
          J_SS: begin
            spread_nxt = spread_r - acc_r[WQ_W-1:0];
            job_nxt    = J_WX;
          end
          J_WX: begin
            dev_nxt = dev_abs[DEV_W-1:0];
            job_nxt = J_DD;
          end
          J_DD: begin
            lhs_nxt = {acc_r[2*DEV_W-1:0], 16'b0};
            job_nxt = J_TT;
          end
          J_TT: begin
            tsq_nxt = acc_r[2*THR_W-1:0];
            job_nxt = J_RHS;
          end
          J_RHS: begin
            // zero spread means z = 0
            anom_nxt = (spread_r != '0) && (ACC_W'(lhs_r) > acc_r);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    x_r      <= x_nxt;
    w_r      <= w_nxt;
    n_r      <= n_nxt;
    full_r   <= full_nxt;
    thr_r    <= thr_nxt;
    addr_r   <= addr_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    sh_r     <= sh_nxt;
    acc_r    <= acc_nxt;
    s_r      <= s_nxt;
    q_r      <= q_nxt;
    spread_r <= spread_nxt;
    dev_r    <= dev_nxt;
    lhs_r    <= lhs_nxt;
    tsq_r    <= tsq_nxt;
    anom_r   <= anom_nxt;
  end

endmodule

// File: sv/sliding_zscore_anomaly_top.sv
// Channel  Ports                        Payload
// -------  ---------------------------  -------------------------------------------
// input    in_ch.valid / in_ch.ready    sample (s24, Q16.8), restart
// result   out_ch.valid / out_ch.ready  anomaly, window_full, anomaly_count (u32)
// config   cfg_we, cfg_index, cfg_data  0: window_len (7b), 1: threshold (16b Q8.8)
//
// One request at a time. With n = min(window_len, samples held), the ring is swept
// one entry per cycle over n entries; with a full window the single 32x32 multiplier
// then forms six products in turn, one digit pair at a time.
// A finished result waits in the output register; the next sample is taken meanwhile.
// rst_n is synchronous; it clears the ring pointers and count and reloads the config defaults.
module sliding_zscore_anomaly_top (
  input  logic                            clk,
  input  logic                            rst_n,
  szs_in_if.sink                          in_ch,
  szs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [szs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [szs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import szs_pkg::*;

  wlen_t   wlen_r;
  thr_t    thr_r;
  idx_t    write_pos_r, write_pos_nxt;
  cnt_t    seen_r;
  count_t  count_r, count_nxt;
  logic    out_valid_r;
  logic    out_anom_r;
  logic    out_full_r;
  count_t  out_count_r;

  logic    accept;
  idx_t    wp;
  cnt_t    seen_base, seen_new;
  wlen_t   w_cl;
  logic    full;
  start_t  start;
  logic    core_ready;
  logic    done_valid, done_ready, done_take;
  result_t result;
  idx_t    rd_addr;
  sample_t rd_data;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = core_ready;

  // restart clears the series before this sample goes in
  assign wp        = in_ch.restart ? '0 : write_pos_r;
  assign seen_base = in_ch.restart ? '0 : seen_r;
  assign seen_new  = (seen_base < CNT_W'(MAX_WINDOW)) ? seen_base + 1'b1 : seen_base;
  assign w_cl      = clamp_wlen(wlen_r);
  assign full      = (KW'(seen_new) >= KW'(w_cl));

  assign write_pos_nxt = (wp == IDX_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;

  assign start.x        = in_ch.sample;
  assign start.w        = w_cl;
  assign start.n        = full ? CNT_W'(w_cl) : seen_new;
  assign start.full     = full;
  assign start.thr      = thr_r;
  assign start.top_addr = wp;

  assign done_ready = !out_valid_r || out_ch.ready;
  assign done_take  = done_valid && done_ready;
  assign count_nxt  = (result.anomaly && count_r != '1) ? count_r + 1'b1 : count_r;

  szs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (in_ch.sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  szs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (in_ch.valid),
    .start_ready (core_ready),
    .start       (start),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .result      (result),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= WLEN_RESET;
      thr_r       <= THR_RESET;
      write_pos_r <= '0;
      seen_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LEN: wlen_r <= cfg_data[WLEN_W-1:0];
          CFG_THRESHOLD:  thr_r  <= cfg_data[THR_W-1:0];
        endcase
      end
      if (accept) begin
        write_pos_r <= write_pos_nxt;
        seen_r      <= seen_new;
        if (in_ch.restart) begin
          count_r <= '0;
        end
      end else if (done_take) begin
        count_r <= count_nxt;
      end
      if (done_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_take) begin
      out_anom_r  <= result.anomaly;
      out_full_r  <= result.window_full;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.anomaly       = out_anom_r;
  assign out_ch.window_full   = out_full_r;
  assign out_ch.anomaly_count = out_count_r;

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import szs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    sample_t sample;
    logic    restart;
  } reading_t;

  typedef struct packed {
    logic   anomaly;
    logic   window_full;
    count_t anomaly_count;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  szs_in_if  in_ch();
  szs_out_if out_ch();

  sliding_zscore_anomaly_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reading_t pending_readings[$];
  verdict_t expected_verdicts[$];
  reading_t next_reading;

  // detector copy: sample history, pointers, count and registers
  longint  sample_hist[MAX_WINDOW];
  int      hist_pos;
  int      hist_seen;
  count_t  anomaly_total;
  wlen_t   win_len_reg;
  thr_t    thresh_reg;

  int      mismatches;
  int      cycles;
  int      send_gap;
  int      recv_stall;
  int      stall_now;
  bit      steady_flow;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic predict_zscore(input sample_t smp, input logic restart);
    longint xs, sum, sumsq, v, spread, dev;
    logic [127:0] dev_w, spread_w, thr_sq, lhs, rhs;
    int w, n;
    bit full, anom;
    verdict_t exp_v;
    xs = $signed(smp);
    anom = 1'b0;
    if (restart) begin
      hist_pos = 0;
      hist_seen = 0;
      anomaly_total = '0;
    end
    sample_hist[hist_pos] = xs;
    hist_pos = (hist_pos + 1) % MAX_WINDOW;
    if (hist_seen < MAX_WINDOW) hist_seen++;
    w = win_len_reg;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    full = hist_seen >= w;
    n = full ? w : hist_seen;
    sum = 0;
    sumsq = 0;
    for (int k = 0; k < n; k++) begin
      v = sample_hist[(hist_pos + MAX_WINDOW - 1 - k) % MAX_WINDOW];
      sum += v;
      sumsq += v * v;
    end
    if (full) begin
      spread = longint'(w) * sumsq - sum * sum;
      if (spread != 0) begin
        dev = longint'(w) * xs - sum;
        if (dev < 0) dev = -dev;
        dev_w = dev;
        spread_w = spread;
        thr_sq = thresh_reg;
        thr_sq = thr_sq * thr_sq;
        lhs = (dev_w * dev_w) << 16;
        rhs = spread_w * thr_sq;
        anom = lhs > rhs;
      end
    end
    if (anom && anomaly_total != '1) anomaly_total++;
    exp_v.anomaly = anom;
    exp_v.window_full = full;
    exp_v.anomaly_count = anomaly_total;
    expected_verdicts.insert(expected_verdicts.size(), exp_v);
  endtask

  task automatic check_verdict();
    verdict_t exp_v;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("result with no request outstanding");
    end else begin
      exp_v = expected_verdicts.pop_front();
      if (out_ch.anomaly !== exp_v.anomaly)
        report_mismatch($sformatf("anomaly got %b exp %b", out_ch.anomaly, exp_v.anomaly));
      if (out_ch.window_full !== exp_v.window_full)
        report_mismatch($sformatf("window_full got %b exp %b",
                                  out_ch.window_full, exp_v.window_full));
      if (out_ch.anomaly_count !== exp_v.anomaly_count)
        report_mismatch($sformatf("anomaly_count got %0d exp %0d",
                                  out_ch.anomaly_count, exp_v.anomaly_count));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_zscore(in_ch.sample, in_ch.restart);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          next_reading = pending_readings.pop_front();
          in_ch.sample <= next_reading.sample;
          in_ch.restart <= next_reading.restart;
          in_ch.valid <= 1'b1;
          send_gap <= steady_flow ? 0 : $urandom_range(0, 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall_now = recv_stall;
      if (out_ch.valid && out_ch.ready) begin
        check_verdict();
        stall_now = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (stall_now != 0) begin
        out_ch.ready <= 1'b0;
        recv_stall <= stall_now - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  function automatic void push_reading(input int val, input bit restart);
    reading_t rd;
    if (val > 8388607) val = 8388607;
    if (val < -8388608) val = -8388608;
    rd.sample = sample_t'(val);
    rd.restart = restart;
    pending_readings.insert(pending_readings.size(), rd);
  endfunction

  // checked on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_readings.size() != 0 || in_ch.valid || expected_verdicts.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // both registers are written back to back while nothing is in flight
  task automatic set_config(input int wl, input int th);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW_LEN;
    cfg_data <= CFG_DATA_W'(wl);
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data <= CFG_DATA_W'(th);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len_reg = wlen_t'(wl);
    thresh_reg = thr_t'(th);
  endtask

  task automatic fill_phase(input int items);
    int base, amp, val, r;
    base = $urandom_range(0, 16777215) - 8388608;
    case ($urandom_range(0, 3))
      0: amp = 0;
      1: amp = $urandom_range(1, 16);
      2: amp = $urandom_range(17, 4096);
      default: amp = $urandom_range(4097, 1 << 20);
    endcase
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        val = $urandom_range(0, 16777215) - 8388608;
      end else if (r < 12) begin
        // outlier well away from the baseline
        val = (amp + 1) * $urandom_range(3, 20) + $urandom_range(0, 255);
        val = $urandom_range(0, 1) ? base + val : base - val;
      end else begin
        val = base + $urandom_range(0, 2 * amp) - amp;
      end
      push_reading(val, (i == 0 && $urandom_range(0, 1)) || $urandom_range(0, 99) < 2);
    end
  endtask

  initial begin
    int wl, th;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW_LEN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    steady_flow = 1'b0;
    hist_pos = 0;
    hist_seen = 0;
    anomaly_total = '0;
    win_len_reg = WLEN_RESET;
    thresh_reg = THR_RESET;
    foreach (sample_hist[i]) sample_hist[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: flat window (zero spread), then extremes as spikes
    push_reading(100, 1'b1);
    repeat (7) push_reading(100, 1'b0);
    push_reading(8388607, 1'b0);
    push_reading(-8388608, 1'b0);
    wait_idle();
    // window of 0 behaves as 1: never any spread
    set_config(0, 0);
    push_reading(5, 1'b0);
    push_reading(-3, 1'b0);
    wait_idle();
    // oversized window clamps to the ring depth
    set_config(127, 65535);
    push_reading(-8388608, 1'b0);
    push_reading(8388607, 1'b0);
    push_reading(0, 1'b0);
    wait_idle();
    // short window applied mid-stream with zero threshold
    set_config(2, 0);
    push_reading(1, 1'b0);
    push_reading(1, 1'b0);
    push_reading(2, 1'b0);
    wait_idle();
    set_config(64, 65535);
    push_reading(-1, 1'b1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 7))
        0: wl = 0;
        1: wl = 1;
        2: wl = 2;
        3: wl = 64;
        4: wl = $urandom_range(65, 127);
        default: wl = $urandom_range(3, 32);
      endcase
      case ($urandom_range(0, 5))
        0: th = 0;
        1: th = 65535;
        2: th = $urandom_range(0, 65535);
        default: th = $urandom_range(128, 1024);
      endcase
      set_config(wl, th);
      steady_flow <= ($urandom_range(0, 3) == 0);
      fill_phase(PHASE_ITEMS);
      wait_idle();
    end

    steady_flow <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sliding_zscore_anomaly_top.f
sv/szs_pkg.sv
sv/szs_in_if.sv
sv/szs_out_if.sv
sv/szs_ram.sv
sv/szs_mul.sv
sv/szs_core.sv
sv/sliding_zscore_anomaly_top.sv
dv/testbench.sv
